/* rtl/core/sad_pkg.sv */
// Shared types and constants for the structure alignment core.
`timescale 1ns / 1ps
package sad_pkg;

    localparam int COORD_W = 20;
    localparam int PT_W    = 3 * COORD_W;
    localparam int SCORE_W = 32;
    localparam int GAIN_W  = 17;
    localparam int D2_W    = 43;
    localparam int NUM_W   = 40;
    localparam int DEN_W   = 44;
    localparam int D0SQ_W  = 24;
    localparam int GAP_W   = 19;

    localparam logic [GAIN_W-1:0] ONE_FIX = 17'h10000;

    localparam logic [1:0] CMD_APPEND_X = 2'd0;
    localparam logic [1:0] CMD_APPEND_Y = 2'd1;
    localparam logic [1:0] CMD_ALIGN    = 2'd2;

    localparam logic CFG_D0SQ = 1'b0;
    localparam logic CFG_GAP  = 1'b1;

    localparam logic [D0SQ_W-1:0] D0SQ_RST = 24'd262144;
    localparam logic [GAP_W-1:0]  GAP_RST  = 19'h76666;  // -39322

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [GAIN_W-1:0] quo;
    } t_div_rsp;

endpackage

/* rtl/core/sad_div.sv */
// Iterative restoring divider, one quotient bit per cycle, 17-bit quotient, 1.0 on a zero divisor.
`timescale 1ns / 1ps
module sad_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sad_pkg::t_div_req  i_req,
    output sad_pkg::t_div_rsp  o_rsp
);
    localparam int STEPS = sad_pkg::GAIN_W;
    localparam int SH_W  = sad_pkg::DEN_W + STEPS - 1;

    logic [4:0]                  r_cnt;
    logic                        r_done;
    logic                        r_zero;
    logic [sad_pkg::NUM_W-1:0]   r_rem;
    logic [SH_W-1:0]             r_dsh;
    logic [sad_pkg::GAIN_W-1:0]  r_quo;
    logic                        w_ge;

    assign w_ge = SH_W'(r_rem) >= r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= 5'(STEPS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.num;
            r_dsh  <= SH_W'(i_req.den) << (STEPS - 1);
            r_quo  <= '0;
            r_zero <= (i_req.den == '0);
        end else if (r_cnt != '0) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dsh[sad_pkg::NUM_W-1:0];
            end
            r_quo <= {r_quo[sad_pkg::GAIN_W-2:0], w_ge};
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_rsp.busy = (r_cnt != '0);
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_zero ? sad_pkg::ONE_FIX : r_quo;

endmodule

/* rtl/core/sad_dist.sv */
// Squared distance of two points over one shared squarer, one axis per cycle.
`timescale 1ns / 1ps
module sad_dist (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [sad_pkg::PT_W-1:0]   i_pa,
    input  logic [sad_pkg::PT_W-1:0]   i_pb,
    output logic                       o_done,
    output logic [sad_pkg::D2_W-1:0]   o_d2
);
    localparam int CW = sad_pkg::COORD_W;

    logic [2:0]                  r_k;
    logic                        r_done;
    logic [sad_pkg::PT_W-1:0]    r_pa;
    logic [sad_pkg::PT_W-1:0]    r_pb;
    logic [40:0]                 r_prod;
    logic [sad_pkg::D2_W-1:0]    r_acc;
    logic [CW-1:0]               w_ca;
    logic [CW-1:0]               w_cb;
    logic signed [CW:0]          w_diff;
    logic signed [2*CW+1:0]      w_sq;

    always_comb begin
        case (r_k)
            3'd1: begin
                w_ca = r_pa[CW-1:0];
                w_cb = r_pb[CW-1:0];
            end
            3'd2: begin
                w_ca = r_pa[2*CW-1:CW];
                w_cb = r_pb[2*CW-1:CW];
            end
            default: begin
                w_ca = r_pa[3*CW-1:2*CW];
                w_cb = r_pb[3*CW-1:2*CW];
            end
        endcase
    end

    assign w_diff = {w_ca[CW-1], w_ca} - {w_cb[CW-1], w_cb};
    assign w_sq   = w_diff * w_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_k <= 3'd1;
            end else if (r_k == 3'd4) begin
                r_k    <= '0;
                r_done <= 1'b1;
            end else if (r_k != '0) begin
                r_k <= r_k + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_pa  <= i_pa;
            r_pb  <= i_pb;
            r_acc <= '0;
        end else begin
            if (r_k >= 3'd1 && r_k <= 3'd3) begin
                r_prod <= 41'(w_sq);
            end
            if (r_k >= 3'd2) begin
                r_acc <= r_acc + sad_pkg::D2_W'(r_prod);
            end
        end
    end

    assign o_done = r_done;
    assign o_d2   = r_acc;

endmodule

/* rtl/core/structure_alignment_dp_core.sv */
// Top level: point stores, score matrix, alignment sequencer and result stream.
`timescale 1ns / 1ps
// Commands 0 and 1 append a point to the first or second list; command 2 aligns the
// lists and streams one result per second-list point. The align runs one matrix cell
// at a time through a shared squared-distance unit (3 multiplies) and a 17-step
// divider, then a traceback over at most n1+n2 steps, a pass over the aligned pairs
// to total the score, the final normalization, and the results, each held until taken.
// The input is not ready while an align runs or results are pending.
module structure_alignment_dp_core #(
    parameter int MAX_LEN = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // coord_x, coord_y, coord_z, zero pad
    input  logic [1:0]  s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // y_index, x_index, aligned, tm_score, first_x,
                                        // first_y, first_found, zero pad
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    localparam int IW  = $clog2(MAX_LEN);
    localparam int CW  = $clog2(MAX_LEN + 1);
    localparam int DIM = MAX_LEN + 1;
    localparam int AW  = $clog2(DIM * DIM);
    localparam int SW  = $clog2(MAX_LEN) + sad_pkg::GAIN_W;
    localparam int PW  = sad_pkg::PT_W;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CRD   = 5'd1;
    localparam logic [4:0] S_CLD   = 5'd2;
    localparam logic [4:0] S_GSQ   = 5'd3;
    localparam logic [4:0] S_GDIV  = 5'd4;
    localparam logic [4:0] S_CUPD  = 5'd5;
    localparam logic [4:0] S_TRD0  = 5'd6;
    localparam logic [4:0] S_TCHK  = 5'd7;
    localparam logic [4:0] S_TRD1  = 5'd8;
    localparam logic [4:0] S_TDEC  = 5'd9;
    localparam logic [4:0] S_SRD   = 5'd10;
    localparam logic [4:0] S_SCHK  = 5'd11;
    localparam logic [4:0] S_SLD   = 5'd12;
    localparam logic [4:0] S_SACC  = 5'd13;
    localparam logic [4:0] S_TMST  = 5'd14;
    localparam logic [4:0] S_TMW   = 5'd15;
    localparam logic [4:0] S_ERD   = 5'd16;
    localparam logic [4:0] S_EOUT  = 5'd17;
    localparam logic [4:0] S_EWAIT = 5'd18;

    // configuration
    logic [sad_pkg::D0SQ_W-1:0]        r_d0sq;
    logic signed [sad_pkg::GAP_W-1:0]  r_gap;

    // control
    logic [4:0]          r_st;
    logic [CW-1:0]       r_cnt1;
    logic [CW-1:0]       r_cnt2;
    logic [CW-1:0]       r_i;
    logic [CW-1:0]       r_j;
    logic                r_in_sum;
    logic [MAX_LEN-1:0]  r_mvld;
    logic                r_ovalid;

    // storage
    logic [PW-1:0]  fp_mem [MAX_LEN];
    logic [PW-1:0]  sp_mem [MAX_LEN];
    logic [32:0]    mm_mem [DIM*DIM];
    logic [IW-1:0]  map_mem [MAX_LEN];
    logic [PW-1:0]  r_fpd;
    logic [PW-1:0]  r_spd;
    logic [32:0]    r_mrd;
    logic           r_mz;
    logic [IW-1:0]  r_mpd;

    // datapath
    logic signed [31:0]          r_up;
    logic                        r_upf;
    logic signed [31:0]          r_left;
    logic                        r_leftf;
    logic signed [31:0]          r_diag;
    logic [SW-1:0]               r_sum;
    logic                        r_ff;
    logic [IW-1:0]               r_fx;
    logic [IW-1:0]               r_fy;
    logic [sad_pkg::GAIN_W-1:0]  r_tm;
    logic [IW-1:0]               r_ox;
    logic [IW-1:0]               r_oy;
    logic                        r_oal;
    logic                        r_olast;

    logic                 w_acc_in;
    logic                 w_acc_cfg;
    logic [IW-1:0]        w_fpa;
    logic [IW-1:0]        w_spa;
    logic [IW-1:0]        w_mpa;
    logic [CW-1:0]        w_mrow;
    logic [CW-1:0]        w_mcol;
    logic [AW-1:0]        w_ma;
    logic [AW-1:0]        w_wa;
    logic                 w_mwe;
    logic signed [31:0]   w_mval;
    logic                 w_mflag;
    logic [CW-1:0]        w_lnorm;
    logic                 w_dstart;
    logic                 w_ddone;
    logic [sad_pkg::D2_W-1:0] w_d2;
    sad_pkg::t_div_req    w_dreq;
    sad_pkg::t_div_rsp    w_drsp;
    logic signed [33:0]   w_gap34;
    logic signed [33:0]   w_d;
    logic signed [33:0]   w_h;
    logic signed [33:0]   w_v;
    logic signed [33:0]   w_vt;
    logic                 w_isdiag;
    logic signed [33:0]   w_res;
    logic                 w_mapv;

    assign w_acc_in  = s_axis_tvalid & s_axis_tready;
    assign w_acc_cfg = i_cfg_valid & o_cfg_ready;
    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_st == S_IDLE);
    assign w_lnorm  = (r_cnt1 < r_cnt2) ? r_cnt1 : r_cnt2;
    assign w_mapv   = r_mvld[r_j[IW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d0sq <= sad_pkg::D0SQ_RST;
            r_gap  <= sad_pkg::GAP_RST;
        end else if (w_acc_cfg) begin
            case (i_cfg_index)
                sad_pkg::CFG_D0SQ: r_d0sq <= i_cfg_data;
                sad_pkg::CFG_GAP:  r_gap  <= i_cfg_data[sad_pkg::GAP_W-1:0];
                default: ;
            endcase
        end
    end

    // address selection
    always_comb begin
        w_fpa  = IW'(r_i - CW'(1));
        w_spa  = IW'(r_j - CW'(1));
        w_mpa  = r_j[IW-1:0];
        w_mrow = r_i - CW'(1);
        w_mcol = r_j;
        case (r_st)
            S_TRD0: begin
                w_mrow = r_i;
            end
            S_TRD1: begin
                w_mrow = r_i;
                w_mcol = r_j - CW'(1);
            end
            S_SCHK, S_SLD, S_GSQ, S_GDIV, S_SACC: begin
                w_fpa = r_mpd;
                w_spa = r_j[IW-1:0];
            end
            default: ;
        endcase
    end

    assign w_ma  = AW'(int'(w_mrow) * DIM + int'(w_mcol));
    assign w_wa  = AW'(int'(r_i) * DIM + int'(r_j));
    assign w_mwe = (r_st == S_CUPD);

    always_ff @(posedge i_clk) begin
        if (w_acc_in && s_axis_tuser == sad_pkg::CMD_APPEND_X && r_cnt1 < CW'(MAX_LEN)) begin
            fp_mem[r_cnt1[IW-1:0]] <= s_axis_tdata[PW-1:0];
        end
        if (w_acc_in && s_axis_tuser == sad_pkg::CMD_APPEND_Y && r_cnt2 < CW'(MAX_LEN)) begin
            sp_mem[r_cnt2[IW-1:0]] <= s_axis_tdata[PW-1:0];
        end
        r_fpd <= fp_mem[w_fpa];
        r_spd <= sp_mem[w_spa];
    end

    always_ff @(posedge i_clk) begin
        if (w_mwe) begin
            mm_mem[w_wa] <= {w_isdiag, w_res[31:0]};
        end
        r_mrd <= mm_mem[w_ma];
        r_mz  <= (w_mrow == '0) || (w_mcol == '0);
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_TCHK && w_mflag) begin
            map_mem[IW'(r_j - CW'(1))] <= IW'(r_i - CW'(1));
        end
        r_mpd <= map_mem[w_mpa];
    end

    assign w_mval  = r_mz ? 32'sd0 : $signed(r_mrd[31:0]);
    assign w_mflag = r_mz ? 1'b0 : r_mrd[32];

    // shared arithmetic
    assign w_dstart = (r_st == S_CLD) || (r_st == S_SLD);

    sad_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_pa    (r_fpd),
        .i_pb    (r_spd),
        .o_done  (w_ddone),
        .o_d2    (w_d2)
    );

    always_comb begin
        if (r_st == S_TMST) begin
            w_dreq.start = (w_lnorm != '0);
            w_dreq.num   = sad_pkg::NUM_W'(r_sum);
            w_dreq.den   = sad_pkg::DEN_W'(w_lnorm);
        end else begin
            w_dreq.start = (r_st == S_GSQ) && w_ddone;
            w_dreq.num   = {r_d0sq, 16'd0};
            w_dreq.den   = sad_pkg::DEN_W'(r_d0sq) + sad_pkg::DEN_W'(w_d2);
        end
    end

    sad_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_rsp   (w_drsp)
    );

    // cell recurrence
    assign w_gap34  = 34'(r_gap);
    assign w_d      = 34'(r_diag) + $signed({17'd0, w_drsp.quo});
    assign w_h      = 34'(r_up) + (r_upf ? w_gap34 : 34'sd0);
    assign w_v      = 34'(r_left) + (r_leftf ? w_gap34 : 34'sd0);
    assign w_vt     = 34'(w_mval) + (w_mflag ? w_gap34 : 34'sd0);
    assign w_isdiag = (w_d >= w_h) && (w_d >= w_v);
    assign w_res    = w_isdiag ? w_d : ((w_v >= w_h) ? w_v : w_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_cnt1   <= '0;
            r_cnt2   <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_in_sum <= 1'b0;
            r_mvld   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            case (r_st)
                S_IDLE: begin
                    if (w_acc_in) begin
                        case (s_axis_tuser)
                            sad_pkg::CMD_APPEND_X: begin
                                if (r_cnt1 < CW'(MAX_LEN)) begin
                                    r_cnt1 <= r_cnt1 + CW'(1);
                                end
                            end
                            sad_pkg::CMD_APPEND_Y: begin
                                if (r_cnt2 < CW'(MAX_LEN)) begin
                                    r_cnt2 <= r_cnt2 + CW'(1);
                                end
                            end
                            sad_pkg::CMD_ALIGN: begin
                                if (r_cnt2 != '0) begin
                                    r_mvld <= '0;
                                    if (r_cnt1 == '0) begin
                                        r_j  <= '0;
                                        r_st <= S_SRD;
                                    end else begin
                                        r_i  <= CW'(1);
                                        r_j  <= CW'(1);
                                        r_st <= S_CRD;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_CRD: begin
                    r_in_sum <= 1'b0;
                    r_st     <= S_CLD;
                end
                S_CLD: r_st <= S_GSQ;
                S_GSQ: begin
                    if (w_ddone) begin
                        r_st <= S_GDIV;
                    end
                end
                S_GDIV: begin
                    if (w_drsp.done) begin
                        r_st <= r_in_sum ? S_SACC : S_CUPD;
                    end
                end
                S_CUPD: begin
                    if (r_j == r_cnt2) begin
                        if (r_i == r_cnt1) begin
                            r_st <= S_TRD0;
                        end else begin
                            r_i  <= r_i + CW'(1);
                            r_j  <= CW'(1);
                            r_st <= S_CRD;
                        end
                    end else begin
                        r_j  <= r_j + CW'(1);
                        r_st <= S_CRD;
                    end
                end
                S_TRD0: r_st <= S_TCHK;
                S_TCHK: begin
                    if (w_mflag) begin
                        r_mvld[IW'(r_j - CW'(1))] <= 1'b1;
                        r_i <= r_i - CW'(1);
                        r_j <= r_j - CW'(1);
                        if (r_i == CW'(1) || r_j == CW'(1)) begin
                            r_j  <= '0;
                            r_st <= S_SRD;
                        end else begin
                            r_st <= S_TRD0;
                        end
                    end else begin
                        r_st <= S_TRD1;
                    end
                end
                S_TRD1: r_st <= S_TDEC;
                S_TDEC: begin
                    if (w_vt >= w_h) begin
                        r_j <= r_j - CW'(1);
                        if (r_j == CW'(1)) begin
                            r_j  <= '0;
                            r_st <= S_SRD;
                        end else begin
                            r_st <= S_TRD0;
                        end
                    end else begin
                        r_i <= r_i - CW'(1);
                        if (r_i == CW'(1)) begin
                            r_j  <= '0;
                            r_st <= S_SRD;
                        end else begin
                            r_st <= S_TRD0;
                        end
                    end
                end
                S_SRD: begin
                    r_in_sum <= 1'b1;
                    r_st     <= S_SCHK;
                end
                S_SCHK: begin
                    if (w_mapv) begin
                        r_st <= S_SLD;
                    end else if (r_j + CW'(1) == r_cnt2) begin
                        r_st <= S_TMST;
                    end else begin
                        r_j  <= r_j + CW'(1);
                        r_st <= S_SRD;
                    end
                end
                S_SLD: r_st <= S_GSQ;
                S_SACC: begin
                    if (r_j + CW'(1) == r_cnt2) begin
                        r_st <= S_TMST;
                    end else begin
                        r_j  <= r_j + CW'(1);
                        r_st <= S_SRD;
                    end
                end
                S_TMST: begin
                    r_j  <= '0;
                    r_st <= (w_lnorm == '0) ? S_ERD : S_TMW;
                end
                S_TMW: begin
                    if (w_drsp.done) begin
                        r_st <= S_ERD;
                    end
                end
                S_ERD: r_st <= S_EOUT;
                S_EOUT: begin
                    r_ovalid <= 1'b1;
                    r_st     <= S_EWAIT;
                end
                S_EWAIT: begin
                    if (m_axis_tready) begin
                        r_ovalid <= 1'b0;
                        if (r_olast) begin
                            r_st <= S_IDLE;
                        end else begin
                            r_j  <= r_j + CW'(1);
                            r_st <= S_ERD;
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_st)
            S_IDLE: begin
                r_diag  <= '0;
                r_left  <= '0;
                r_leftf <= 1'b0;
                r_sum   <= '0;
                r_ff    <= 1'b0;
                r_fx    <= '0;
                r_fy    <= '0;
            end
            S_CLD: begin
                r_up  <= w_mval;
                r_upf <= w_mflag;
            end
            S_CUPD: begin
                if (r_j == r_cnt2) begin
                    r_diag  <= '0;
                    r_left  <= '0;
                    r_leftf <= 1'b0;
                end else begin
                    r_diag  <= r_up;
                    r_left  <= w_res[31:0];
                    r_leftf <= w_isdiag;
                end
            end
            S_TRD1: begin
                r_up  <= w_mval;
                r_upf <= w_mflag;
            end
            S_SACC: begin
                r_sum <= r_sum + SW'(w_drsp.quo);
                if (!r_ff) begin
                    r_ff <= 1'b1;
                    r_fx <= r_mpd;
                    r_fy <= r_j[IW-1:0];
                end
            end
            S_TMST: begin
                r_tm <= '0;
            end
            S_TMW: begin
                if (w_drsp.done) begin
                    r_tm <= w_drsp.quo;
                end
            end
            S_EOUT: begin
                r_oy    <= r_j[IW-1:0];
                r_ox    <= w_mapv ? r_mpd : '0;
                r_oal   <= w_mapv;
                r_olast <= (r_j + CW'(1) == r_cnt2);
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {5'd0, r_ff, 6'(r_fy), 6'(r_fx), r_tm, r_oal, 6'(r_ox), 6'(r_oy)};

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input ready while a result is pending");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt1 <= CW'(MAX_LEN)) && (r_cnt2 <= CW'(MAX_LEN)))
        else $error("point count beyond capacity");

    a_out_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_j < r_cnt2))
        else $error("result index beyond second list");

    a_cell_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_CUPD) |-> (r_i != '0 && r_i <= r_cnt1 && r_j != '0 && r_j <= r_cnt2))
        else $error("matrix cell outside the loaded lists");

endmodule
